>>> rtl/word_sorter_with_key_check_unit_defines.svh
// assertion macros used by the sorter top file
`ifndef WORD_SORTER_WITH_KEY_CHECK_UNIT_DEFINES_SVH
`define WORD_SORTER_WITH_KEY_CHECK_UNIT_DEFINES_SVH

// implication checked on the same edge
`define WSKC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wskc check failed");

// implication checked on the next edge
`define WSKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wskc check failed");

`endif

>>> rtl/wskc_pkg.sv
package wskc_pkg;

   // request commands
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // register indexes
   localparam logic CSR_MODE      = 1'b0;
   localparam logic CSR_KEY_SHIFT = 1'b1;

   // modes and result kinds
   localparam logic MODE_SORT   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_WORD    = 1'b1;

   localparam logic [5:0] KEY_SHIFT_RESET = 6'd9;
   localparam logic [9:0] COUNT_MAX       = 10'd1023;

   // controller to datapath
   typedef struct packed {
      logic issue;
      logic tail;
      logic restart;
      logic emit;
      logic idle;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic close_go;
      logic empty;
      logic issue_last;
      logic viol_seen;
      logic out_free;
      logic sort_mode;
   } ctrl_status_type;

endpackage

>>> rtl/wskc_ram.sv
module wskc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/wskc_ctrl.sv
module wskc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  wskc_pkg::ctrl_status_type status,
   output wskc_pkg::ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PASS   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_TAIL   = 3'd3;
   localparam logic [2:0] S_REPORT = 3'd4;

   logic [2:0] state_ff, state_in;

   // pass sequencing: walk, drain, tail write, repeat or report
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.idle    = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (status.close_go) begin
               state_in = status.empty ? S_REPORT : S_PASS;
            end
         end
         S_PASS: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_TAIL;
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            if (status.sort_mode && status.viol_seen) begin
               cmd.restart = 1'b1;
               state_in    = S_PASS;
            end else begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/wskc_dp.sv
module wskc_dp #(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_command,
   input  logic [63:0]               req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic [63:0]               rsp_word_out,
   output logic [10:0]               rsp_entry_count,
   output logic [9:0]                rsp_misorder_count,
   output logic [9:0]                rsp_duplicate_keys,
   output logic                      rsp_verdict,
   output logic                      rsp_overflowed,
   output logic                      rsp_last_word,
   output logic                      rsp_past_end,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [5:0]                csr_data,
   input  wskc_pkg::ctrl_cmd_type    cmd,
   output wskc_pkg::ctrl_status_type status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic          closed_ff, closed_in;
   logic          ovf_ff, ovf_in;
   logic          mode_ff;
   logic [5:0]    kshift_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic          dv_ff;
   logic [AW-1:0] dat_idx_ff;
   logic          first_ff, first_in;
   logic [63:0]   carry_ff, carry_in;
   logic          viol_ff, viol_in;
   logic [9:0]    bad_ff, bad_in;
   logic [9:0]    dup_ff, dup_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_past_ff, rd_past_in;
   logic          rd_last_ff, rd_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          kind_ff;
   logic [63:0]   word_out_ff;
   logic [10:0]   entry_ff;
   logic [9:0]    obad_ff;
   logic [9:0]    odup_ff;
   logic          verdict_ff, ovfl_ff, last_ff, past_ff;

   logic          accept, out_free, sort_mode;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [63:0]   ram_wdata, ram_rdata;
   logic          less, key_eq, proc;
   logic [63:0]   key_diff;

   assign sort_mode = (mode_ff == wskc_pkg::MODE_SORT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !cmd.idle || rd_pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // compare of the incoming word against the carried word
   assign proc     = dv_ff && !first_ff;
   assign less     = ram_rdata < carry_ff;
   assign key_diff = (ram_rdata ^ carry_ff) >> kshift_ff;
   assign key_eq   = (key_diff == 64'd0);

   // store port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = req_word;
      if (accept && req_command == wskc_pkg::CMD_LOAD) begin
         if (closed_ff) begin
            ram_we = 1'b1;
         end else if (fill_ff < CW'(DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_ff[AW-1:0];
         end
      end else if (proc && sort_mode) begin
         ram_we    = 1'b1;
         ram_waddr = dat_idx_ff - AW'(1);
         ram_wdata = less ? ram_rdata : carry_ff;
      end else if (cmd.tail && sort_mode) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(fill_ff - CW'(1));
         ram_wdata = carry_ff;
      end
   end

   assign ram_raddr = cmd.issue ? idx_ff : rp_ff[AW-1:0];

   wskc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // set bookkeeping, read requests and pass counters
   always_comb begin
      fill_in    = fill_ff;
      rp_in      = rp_ff;
      closed_in  = closed_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      carry_in   = carry_ff;
      viol_in    = viol_ff;
      bad_in     = bad_ff;
      dup_in     = dup_ff;
      rd_pend_in = 1'b0;
      rd_past_in = rd_past_ff;
      rd_last_in = rd_last_ff;
      if (accept) begin
         case (req_command)
            wskc_pkg::CMD_LOAD: begin
               if (closed_ff) begin
                  fill_in   = CW'(1);
                  rp_in     = '0;
                  closed_in = 1'b0;
                  ovf_in    = 1'b0;
               end else if (fill_ff < CW'(DEPTH)) begin
                  fill_in = fill_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            wskc_pkg::CMD_CLOSE: begin
               closed_in = 1'b1;
               rp_in     = '0;
            end
            wskc_pkg::CMD_READ: begin
               rd_pend_in = 1'b1;
               if (!closed_ff || rp_ff >= fill_ff) begin
                  rd_past_in = 1'b1;
                  rd_last_in = 1'b0;
               end else begin
                  rd_past_in = 1'b0;
                  rd_last_in = (rp_ff + CW'(1) == fill_ff);
                  rp_in      = rp_ff + CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.issue) begin
         idx_in = idx_ff + AW'(1);
      end
      if (dv_ff) begin
         if (first_ff) begin
            first_in = 1'b0;
            carry_in = ram_rdata;
         end else begin
            carry_in = (sort_mode && less) ? carry_ff : ram_rdata;
            if (less) begin
               viol_in = 1'b1;
               if (bad_ff != wskc_pkg::COUNT_MAX) begin
                  bad_in = bad_ff + 10'd1;
               end
            end
            if (key_eq && dup_ff != wskc_pkg::COUNT_MAX) begin
               dup_in = dup_ff + 10'd1;
            end
         end
      end
      // fresh pass after close or after a pass that swapped
      if ((accept && req_command == wskc_pkg::CMD_CLOSE) || cmd.restart) begin
         idx_in   = '0;
         first_in = 1'b1;
         viol_in  = 1'b0;
         bad_in   = '0;
         dup_in   = '0;
      end
   end

   // result register
   assign rsp_valid_in = rd_pend_ff || cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rp_ff        <= '0;
         closed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         kshift_ff    <= wskc_pkg::KEY_SHIFT_RESET;
         dv_ff        <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rp_ff        <= rp_in;
         closed_ff    <= closed_in;
         ovf_ff       <= ovf_in;
         dv_ff        <= cmd.issue;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == wskc_pkg::CSR_MODE) begin
            mode_ff <= csr_data[0];
         end
         if (csr_wr_en && csr_index == wskc_pkg::CSR_KEY_SHIFT) begin
            kshift_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      dat_idx_ff <= idx_ff;
      first_ff   <= first_in;
      carry_ff   <= carry_in;
      viol_ff    <= viol_in;
      bad_ff     <= bad_in;
      dup_ff     <= dup_in;
      rd_past_ff <= rd_past_in;
      rd_last_ff <= rd_last_in;
      if (rd_pend_ff) begin
         kind_ff     <= wskc_pkg::KIND_WORD;
         word_out_ff <= rd_past_ff ? 64'd0 : ram_rdata;
         entry_ff    <= '0;
         obad_ff     <= '0;
         odup_ff     <= '0;
         verdict_ff  <= 1'b0;
         ovfl_ff     <= 1'b0;
         last_ff     <= rd_last_ff;
         past_ff     <= rd_past_ff;
      end else if (cmd.emit) begin
         kind_ff     <= wskc_pkg::KIND_SUMMARY;
         word_out_ff <= 64'd0;
         entry_ff    <= (32'(fill_ff) > 32'd2047) ? 11'd2047 : 11'(fill_ff);
         obad_ff     <= bad_ff;
         odup_ff     <= dup_ff;
         verdict_ff  <= (bad_ff != 10'd0) || (dup_ff != 10'd0);
         ovfl_ff     <= ovf_ff;
         last_ff     <= 1'b0;
         past_ff     <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_word_out       = word_out_ff;
   assign rsp_entry_count    = entry_ff;
   assign rsp_misorder_count = obad_ff;
   assign rsp_duplicate_keys = odup_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_overflowed     = ovfl_ff;
   assign rsp_last_word      = last_ff;
   assign rsp_past_end       = past_ff;

   // status to the controller
   always_comb begin
      status            = '0;
      status.close_go   = accept && (req_command == wskc_pkg::CMD_CLOSE);
      status.empty      = (fill_ff == '0);
      status.issue_last = (CW'(idx_ff) + CW'(1) == fill_ff);
      status.viol_seen  = viol_ff;
      status.out_free   = out_free;
      status.sort_mode  = sort_mode;
   end

endmodule

>>> rtl/word_sorter_with_key_check_unit.sv
// word sorter with key check
// req channel: command (load, close, read) and a 64-bit word, valid/stall.
// rsp channel: one result per close (summary) or read (stored word).
// csr port: index 0 mode (0 sort, 1 check order), index 1 key shift; write
// only while idle.
// loads give no result. a read result is registered first as a pending read
// and then in the result register; the next request is taken at the earliest
// on the edge that moves that result on.
// close walks the store through a memory with one write and one read port,
// one word a cycle: check mode makes a single pass, sort mode runs bubble
// passes until a pass finds the set in order, at most n passes for n stored
// words; the summary follows.
// while the result register holds a stalled result, req stalls.
// reset empties the set, sets mode 0 and key shift 9; store contents are
// left as they were and are never read before being written.
`include "word_sorter_with_key_check_unit_defines.svh"

module word_sorter_with_key_check_unit #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [63:0] rsp_word_out,
   output logic [10:0] rsp_entry_count,
   output logic [9:0]  rsp_misorder_count,
   output logic [9:0]  rsp_duplicate_keys,
   output logic        rsp_verdict,
   output logic        rsp_overflowed,
   output logic        rsp_last_word,
   output logic        rsp_past_end,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   wskc_pkg::ctrl_cmd_type    cmd;
   wskc_pkg::ctrl_status_type status;

   wskc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   wskc_dp #(.DEPTH(DEPTH)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_word           (req_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_word_out       (rsp_word_out),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_misorder_count (rsp_misorder_count),
      .rsp_duplicate_keys (rsp_duplicate_keys),
      .rsp_verdict        (rsp_verdict),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_last_word      (rsp_last_word),
      .rsp_past_end       (rsp_past_end),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .status             (status)
   );

   // no request taken while a close is being worked through
   `WSKC_ASSERT_SAME(a_busy_stalls, clock, reset, !cmd.idle, req_stall)
   // a summary carries no word and no read flags
   `WSKC_ASSERT_SAME(a_summary_clean, clock, reset,
      rsp_valid && rsp_kind == wskc_pkg::KIND_SUMMARY,
      rsp_word_out == 64'd0 && !rsp_last_word && !rsp_past_end)
   // the summary follows the walk with the set in order in sort mode
   `WSKC_ASSERT_NEXT(a_sorted_clean, clock, reset,
      cmd.emit && status.sort_mode, rsp_misorder_count == 10'd0)

endmodule

>>> test/word_sorter_checker.sv
`default_nettype none

module word_sorter_checker
   import wskc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_word,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_kind,
   input  wire logic [63:0] rsp_word_out,
   input  wire logic [10:0] rsp_entry_count,
   input  wire logic [9:0]  rsp_misorder_count,
   input  wire logic [9:0]  rsp_duplicate_keys,
   input  wire logic        rsp_verdict,
   input  wire logic        rsp_overflowed,
   input  wire logic        rsp_last_word,
   input  wire logic        rsp_past_end,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [5:0]  csr_data,
   output int               fail_count,
   output int               pending,
   output int               summaries_seen,
   output int               words_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1024;

   typedef struct packed {
      logic        kind;
      logic [63:0] word_out;
      logic [10:0] entry_count;
      logic [9:0]  misorder_count;
      logic [9:0]  duplicate_keys;
      logic        verdict;
      logic        overflowed;
      logic        last_word;
      logic        past_end;
   } sorter_result_type;

   // model copy of the block state
   logic [63:0] word_mem [STORE_DEPTH];
   int          fill_level;
   int          read_index;
   bit          set_done;
   bit          dropped_load;
   logic        check_mode;
   logic [5:0]  shift_amount;

   sorter_result_type expected_results[$];

   initial begin
      fail_count     = 0;
      pending        = 0;
      summaries_seen = 0;
      words_seen     = 0;
   end

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
      fail_count++;
   endtask

   // sort mode puts the set in ascending order; then count violations (check mode only) and equal keys
   function automatic sorter_result_type summarise_set();
      sorter_result_type r;
      logic [63:0]       v;
      int                j;
      int                bad;
      int                dup;
      bad = 0;
      dup = 0;
      r   = '0;
      if (check_mode == MODE_SORT) begin
         for (int i = 1; i < fill_level; i++) begin
            v = word_mem[i];
            j = i;
            while (j > 0 && word_mem[j-1] > v) begin
               word_mem[j] = word_mem[j-1];
               j--;
            end
            word_mem[j] = v;
         end
      end
      for (int i = 1; i < fill_level; i++) begin
         if (check_mode != MODE_SORT && word_mem[i] < word_mem[i-1]) bad++;
         if ((word_mem[i] >> shift_amount) == (word_mem[i-1] >> shift_amount)) dup++;
      end
      r.kind           = KIND_SUMMARY;
      r.entry_count    = 11'(fill_level);
      r.misorder_count = 10'(bad > 1023 ? 1023 : bad);
      r.duplicate_keys = 10'(dup > 1023 ? 1023 : dup);
      r.verdict        = (bad != 0 || dup != 0);
      r.overflowed     = dropped_load;
      return r;
   endfunction

   // work out the result a request causes, if any
   task automatic predict_request(logic [1:0] cmd, logic [63:0] w);
      sorter_result_type r;
      r = '0;
      case (cmd)
         CMD_LOAD: begin
            if (set_done) begin
               fill_level   = 0;
               read_index   = 0;
               set_done     = 0;
               dropped_load = 0;
            end
            if (fill_level < STORE_DEPTH) begin
               word_mem[fill_level] = w;
               fill_level++;
            end else begin
               dropped_load = 1;
            end
         end
         CMD_CLOSE: begin
            r          = summarise_set();
            set_done   = 1;
            read_index = 0;
            expected_results.push_back(r);
         end
         CMD_READ: begin
            r.kind = KIND_WORD;
            if (!set_done || read_index >= fill_level) begin
               r.past_end = 1;
            end else begin
               r.word_out  = word_mem[read_index];
               r.last_word = (read_index + 1 == fill_level);
               read_index++;
            end
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic compare_result();
      sorter_result_type want;
      if (expected_results.size() == 0) begin
         report("result with none expected", rsp_word_out, 64'd0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_kind == KIND_SUMMARY) summaries_seen++;
      else words_seen++;
      if (rsp_kind != want.kind) report("kind", rsp_kind, want.kind);
      if (rsp_word_out != want.word_out) report("word_out", rsp_word_out, want.word_out);
      if (rsp_entry_count != want.entry_count)
         report("entry_count", rsp_entry_count, want.entry_count);
      if (rsp_misorder_count != want.misorder_count)
         report("misorder_count", rsp_misorder_count, want.misorder_count);
      if (rsp_duplicate_keys != want.duplicate_keys)
         report("duplicate_keys", rsp_duplicate_keys, want.duplicate_keys);
      if (rsp_verdict != want.verdict) report("verdict", rsp_verdict, want.verdict);
      if (rsp_overflowed != want.overflowed)
         report("overflowed", rsp_overflowed, want.overflowed);
      if (rsp_last_word != want.last_word) report("last_word", rsp_last_word, want.last_word);
      if (rsp_past_end != want.past_end) report("past_end", rsp_past_end, want.past_end);
   endtask

   // watch the ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         fill_level   = 0;
         read_index   = 0;
         set_done     = 0;
         dropped_load = 0;
         check_mode   = MODE_SORT;
         shift_amount = KEY_SHIFT_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result();
         if (csr_wr_en) begin
            if (csr_index == CSR_MODE) check_mode = csr_data[0];
            else shift_amount = csr_data;
         end
         if (req_valid && !req_stall) predict_request(req_command, req_word);
      end
      pending = expected_results.size();
   end

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wskc_pkg::*;

   localparam logic [1:0] CMD_NONE  = 2'd3;
   localparam int         CYCLE_CAP = 4000000;
   localparam int         ITEM_GOAL = 1600;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_LOAD;
   logic [63:0] req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_kind;
   logic [63:0] rsp_word_out;
   logic [10:0] rsp_entry_count;
   logic [9:0]  rsp_misorder_count;
   logic [9:0]  rsp_duplicate_keys;
   logic        rsp_verdict;
   logic        rsp_overflowed;
   logic        rsp_last_word;
   logic        rsp_past_end;
   logic        csr_wr_en = 0;
   logic        csr_index = CSR_MODE;
   logic [5:0]  csr_data = '0;

   int fail_count, pending, summaries_seen, words_seen;
   int items_sent = 0;
   int cycles = 0;
   bit gaps_on = 1;
   bit hold_req = 0;

   word_sorter_with_key_check_unit dut (.*);

   word_sorter_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side stall: runs of random length, plus one long hold-off
   initial begin
      int run_left;
      bit stalling;
      int r;
      run_left = 0;
      stalling = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 0;
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            rsp_stall = 0;
            run_left  = 0;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               stalling = (r < 45);
               if (r < 40) run_left = $urandom_range(1, 3);
               else if (r < 45) run_left = $urandom_range(15, 60);
               else if (r < 90) run_left = $urandom_range(1, 6);
               else run_left = $urandom_range(50, 200);
            end
            run_left--;
            rsp_stall = stalling;
         end
      end
   end

   // one request transfer, entered and left at a falling edge
   task automatic send(logic [1:0] cmd, logic [63:0] w);
      int g;
      g = gaps_on ? pick_gap() : 0;
      if (g > 0) begin
         req_valid = 0;
         repeat (g) @(negedge clock);
      end
      req_valid   = 1;
      req_command = cmd;
      req_word    = w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // wait until every expected result has arrived, then let the block settle
   task automatic drain();
      req_valid = 0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [5:0] d);
      csr_wr_en = 1;
      csr_index = idx;
      csr_data  = d;
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // one set with random content and a random read pattern
   task automatic random_set(bit big);
      int          n;
      int          style;
      logic [63:0] base;
      logic [63:0] w;
      n     = big ? $urandom_range(21, 48) : $urandom_range(0, 20);
      style = $urandom_range(0, 3);
      base  = rand_word();
      if ($urandom_range(0, 9) == 0) send(CMD_READ, rand_word());
      if ($urandom_range(0, 14) == 0) send(CMD_NONE, rand_word());
      for (int i = 0; i < n; i++) begin
         case (style)
            0: w = rand_word();
            1: w = base + 64'($urandom_range(0, 1500));
            2: w = base + 64'(i * $urandom_range(0, 700));
            default: w = base - 64'(i * $urandom_range(0, 700));
         endcase
         send(CMD_LOAD, w);
      end
      send(CMD_CLOSE, rand_word());
      if ($urandom_range(0, 6) == 0) send(CMD_CLOSE, '0);
      for (int i = $urandom_range(0, 3) == 0 ? $urandom_range(0, n) : n + $urandom_range(0, 2);
           i > 0; i--)
         send(CMD_READ, rand_word());
      if ($urandom_range(0, 7) == 0) begin
         send(CMD_CLOSE, '0);
         send(CMD_READ, '0);
      end
   endtask

   function automatic logic [5:0] pick_shift();
      case ($urandom_range(0, 4))
         0: return 6'd0;
         1: return 6'd63;
         2: return KEY_SHIFT_RESET;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   initial begin
      int phase;
      repeat (5) @(negedge clock);
      reset = 0;

      // directed: read before close, empty set, extreme words, equal keys
      send(CMD_READ, '0);
      send(CMD_CLOSE, '0);
      send(CMD_READ, '1);
      send(CMD_LOAD, '1);
      send(CMD_LOAD, 64'h200);
      send(CMD_LOAD, '0);
      send(CMD_LOAD, 64'h201);
      send(CMD_NONE, '1);
      send(CMD_CLOSE, '0);
      repeat (5) send(CMD_READ, '0);
      drain();
      write_reg(CSR_MODE, 6'd1);
      write_reg(CSR_KEY_SHIFT, 6'd0);
      send(CMD_LOAD, 64'h8000_0000_0000_0000);
      send(CMD_LOAD, 64'h5);
      send(CMD_LOAD, 64'h5);
      send(CMD_CLOSE, '0);
      send(CMD_READ, '0);
      send(CMD_CLOSE, '0);
      send(CMD_READ, '0);
      drain();
      write_reg(CSR_KEY_SHIFT, 6'd63);
      send(CMD_CLOSE, '0);
      send(CMD_READ, '0);

      // full store in check mode, with dropped loads
      for (int i = 0; i < 1027; i++) send(CMD_LOAD, 64'(i) << 20 | 64'($urandom_range(0, 3)));
      send(CMD_CLOSE, '0);
      repeat (3) send(CMD_READ, '0);
      drain();
      // an ordered full set sorts in one pass
      write_reg(CSR_MODE, 6'(MODE_SORT));
      send(CMD_CLOSE, '0);
      repeat (2) send(CMD_READ, '0);

      // long hold-off on results while reads keep coming
      drain();
      for (int i = 0; i < 30; i++) send(CMD_LOAD, rand_word());
      send(CMD_CLOSE, '0);
      drain();
      hold_req = 1;
      repeat (30) send(CMD_READ, '0);

      // random phases with fresh settings
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         drain();
         write_reg(CSR_MODE, 6'($urandom_range(0, 1)));
         write_reg(CSR_KEY_SHIFT, pick_shift());
         gaps_on = (phase % 4 != 3);
         for (int s = 0; s < 6; s++) random_set($urandom_range(0, 9) == 0);
         phase++;
      end

      drain();
      repeat (20) @(negedge clock);
      $display("%0d requests in %0d phases: %0d summaries and %0d stored words checked",
               items_sent, phase, summaries_seen, words_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/wskc_pkg.sv
rtl/wskc_ram.sv
rtl/wskc_ctrl.sv
rtl/wskc_dp.sv
rtl/word_sorter_with_key_check_unit.sv
test/word_sorter_checker.sv
test/tb.sv
